### design/qgrc_pkg.sv
`default_nettype none

package qgrc_pkg;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_REPORT  = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_ADJUST  = 2'd3
    } mode_t;

    typedef struct packed {
        logic acquire;
        logic release_space;
        logic preacquire;
        logic report;
    } req_flags_t;

endpackage

`default_nettype wire

### design/qgrc_calc.sv
`default_nettype none

module qgrc_calc #(
    parameter int SPACE_WIDTH = 64
) (
    input  qgrc_pkg::mode_t          mode,
    input  logic                     enforced,
    input  logic [SPACE_WIDTH-1:0]   disk_usage,
    input  logic [SPACE_WIDTH-1:0]   pending_writes,
    input  logic [SPACE_WIDTH-1:0]   waiting_writes,
    input  logic [SPACE_WIDTH-1:0]   granted_space,
    input  logic [SPACE_WIDTH-1:0]   pending_release,
    input  logic [SPACE_WIDTH-1:0]   quota_unit,
    input  logic [SPACE_WIDTH-1:0]   tune_margin,
    input  logic                     over_quota,
    input  logic                     no_preacquire,
    input  logic                     id_lock_held,
    input  logic                     target_stopping,
    output qgrc_pkg::req_flags_t     flags,
    output logic [SPACE_WIDTH-1:0]   request_count,
    output logic [SPACE_WIDTH-1:0]   reported_usage,
    output logic                     adjust_needed
);
    import qgrc_pkg::*;

    // Three guard bits: the widest sum has five space-sized terms.
    localparam int XW = SPACE_WIDTH + 3;

    function automatic logic [SPACE_WIDTH-1:0] sat(input logic [XW-1:0] v);
        logic [SPACE_WIDTH-1:0] r;
        if (|v[XW-1:SPACE_WIDTH])
            r = '1;
        else
            r = v[SPACE_WIDTH-1:0];
        return r;
    endfunction

    logic [XW-1:0] du_x, gr_x, qu_x, qt_x, pr_x;
    logic [XW-1:0] tot, tot_qu, tot_qt, tot_qu_pr, tot_qt_pr;
    logic [XW-1:0] g_sel, shrink, shrink_unit;
    logic          disk_gt_gr, disk_lt_gr, fall_to_report, pre_ok;

    assign du_x = {{3{1'b0}}, disk_usage};
    assign gr_x = {{3{1'b0}}, granted_space};
    assign qu_x = {{3{1'b0}}, quota_unit};
    assign qt_x = {{3{1'b0}}, tune_margin};
    assign pr_x = {{3{1'b0}}, pending_release};

    assign tot = du_x + {{3{1'b0}}, pending_writes} + {{3{1'b0}}, waiting_writes};
    assign tot_qu    = tot + qu_x;
    assign tot_qt    = tot + qt_x;
    assign tot_qu_pr = tot_qu + pr_x;
    assign tot_qt_pr = tot_qt + pr_x;

    assign disk_gt_gr = disk_usage > granted_space;
    assign disk_lt_gr = disk_usage < granted_space;
    assign fall_to_report = !id_lock_held && disk_lt_gr;
    // Usage above the grant is reported and then stands in for the grant.
    assign g_sel  = disk_gt_gr ? du_x : gr_x;
    assign pre_ok = !over_quota && !no_preacquire && (quota_unit != '0);

    // Adjust mode releases the whole grant when nothing is in use, else it
    // keeps one unit spare, yet never releases below the tuning margin.
    assign shrink      = gr_x - tot;
    assign shrink_unit = shrink - qu_x;

    always_comb
    begin
        logic op_report;
        logic op_release;
        flags          = '0;
        request_count  = '0;
        reported_usage = '0;
        op_report      = 1'b0;
        op_release     = 1'b0;

        if (enforced || (mode == MODE_RELEASE))
        begin
            unique case (mode)
                MODE_ADJUST:
                begin
                    if (fall_to_report)
                        op_report = 1'b1;
                    else if (tot_qu < gr_x)
                    begin
                        flags.release_space = 1'b1;
                        if (tot == '0)
                            request_count = sat(shrink);
                        else if (shrink_unit < qt_x)
                            request_count = tune_margin;
                        else
                            request_count = sat(shrink_unit);
                    end
                    else
                    begin
                        if (disk_gt_gr)
                        begin
                            flags.report   = 1'b1;
                            reported_usage = disk_usage;
                        end
                        if (pre_ok && id_lock_held && (g_sel < tot_qt))
                        begin
                            flags.preacquire = 1'b1;
                            request_count = (tot < g_sel) ? sat(g_sel - tot) : '0;
                        end
                    end
                end
                MODE_REPORT:  op_report  = 1'b1;
                MODE_RELEASE: op_release = 1'b1;
                MODE_ACQUIRE:
                begin
                    if (disk_gt_gr)
                    begin
                        flags.report   = 1'b1;
                        reported_usage = disk_usage;
                    end
                    if (g_sel < tot)
                    begin
                        flags.acquire = 1'b1;
                        request_count = sat(tot - g_sel);
                    end
                end
                default: ;
            endcase

            if (op_report)
            begin
                priority if ((disk_usage == '0) && (granted_space != '0))
                    op_release = 1'b1;
                else if (disk_lt_gr)
                    flags.acquire = 1'b1;
                else if (disk_gt_gr)
                begin
                    flags.report   = 1'b1;
                    reported_usage = disk_usage;
                end
            end

            if (op_release && disk_lt_gr)
            begin
                flags.release_space = 1'b1;
                request_count = granted_space - disk_usage;
            end
        end
    end

    assign adjust_needed = enforced && !target_stopping &&
                           (fall_to_report || (tot_qu_pr < gr_x) || disk_gt_gr ||
                            (pre_ok && (gr_x < tot_qt_pr)));

endmodule

`default_nettype wire

### design/quota_grant_request_calc.sv
// Quota grant request calculator.
//
// Input channel: one quota entry snapshot and a mode per item, moved on
// in_valid with in_stall low. Output channel: the request decision, flags,
// count, reported usage and the adjustment indication, moved on out_valid
// with out_stall low. The user must write the single setting target_stopping
// via cfg_we and cfg_data only while idle; the block does not enforce this.
//
// Every item passes an input register, one level of compare and subtract
// logic, and the result register, from which it leaves on the output
// channel. One item is accepted every cycle while the receiver does not
// stall; the input and result registers form a two-stage pipeline.
//
// Reset clears both stage valid bits and target_stopping. When the
// receiver stalls, the held result stays put; the input register still
// takes one more item, after which in_stall follows out_stall.
`default_nettype none

module quota_grant_request_calc #(
    parameter int SPACE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             mode,
    input  logic                   enforced,
    input  logic [SPACE_WIDTH-1:0] disk_usage,
    input  logic [SPACE_WIDTH-1:0] pending_writes,
    input  logic [SPACE_WIDTH-1:0] waiting_writes,
    input  logic [SPACE_WIDTH-1:0] granted_space,
    input  logic [SPACE_WIDTH-1:0] pending_release,
    input  logic [SPACE_WIDTH-1:0] quota_unit,
    input  logic [SPACE_WIDTH-1:0] tune_margin,
    input  logic                   over_quota,
    input  logic                   no_preacquire,
    input  logic                   id_lock_held,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   request_needed,
    output logic                   flag_acquire,
    output logic                   flag_release,
    output logic                   flag_preacquire,
    output logic                   flag_report,
    output logic [SPACE_WIDTH-1:0] request_count,
    output logic [SPACE_WIDTH-1:0] reported_usage,
    output logic                   adjust_needed
);
    import qgrc_pkg::*;

    logic                   stopping_reg;
    logic                   in_v_reg;
    logic                   out_v_reg;
    logic                   out_ready;
    logic                   in_take;

    mode_t                  mode_reg;
    logic                   enforced_reg;
    logic [SPACE_WIDTH-1:0] disk_reg, pw_reg, ww_reg, granted_reg;
    logic [SPACE_WIDTH-1:0] prel_reg, qunit_reg, qtune_reg;
    logic                   edq_reg, nopre_reg, lock_reg;

    req_flags_t             flags_next, flags_reg;
    logic [SPACE_WIDTH-1:0] count_next, count_reg;
    logic [SPACE_WIDTH-1:0] usage_next, usage_reg;
    logic                   adj_next, adj_reg;

    assign out_ready = !out_v_reg || !out_stall;
    assign in_stall  = in_v_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopping_reg <= 1'b0;
            in_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                stopping_reg <= cfg_data;
            if (!in_stall)
                in_v_reg <= in_valid;
            if (out_ready)
                out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg     <= mode_t'(mode);
            enforced_reg <= enforced;
            disk_reg     <= disk_usage;
            pw_reg       <= pending_writes;
            ww_reg       <= waiting_writes;
            granted_reg  <= granted_space;
            prel_reg     <= pending_release;
            qunit_reg    <= quota_unit;
            qtune_reg    <= tune_margin;
            edq_reg      <= over_quota;
            nopre_reg    <= no_preacquire;
            lock_reg     <= id_lock_held;
        end
        if (out_ready && in_v_reg)
        begin
            flags_reg <= flags_next;
            count_reg <= count_next;
            usage_reg <= usage_next;
            adj_reg   <= adj_next;
        end
    end

    qgrc_calc #(
        .SPACE_WIDTH (SPACE_WIDTH)
    ) u_calc (
        .mode            (mode_reg),
        .enforced        (enforced_reg),
        .disk_usage      (disk_reg),
        .pending_writes  (pw_reg),
        .waiting_writes  (ww_reg),
        .granted_space   (granted_reg),
        .pending_release (prel_reg),
        .quota_unit      (qunit_reg),
        .tune_margin     (qtune_reg),
        .over_quota      (edq_reg),
        .no_preacquire   (nopre_reg),
        .id_lock_held    (lock_reg),
        .target_stopping (stopping_reg),
        .flags           (flags_next),
        .request_count   (count_next),
        .reported_usage  (usage_next),
        .adjust_needed   (adj_next)
    );

    assign out_valid       = out_v_reg;
    assign flag_acquire    = flags_reg.acquire;
    assign flag_release    = flags_reg.release_space;
    assign flag_preacquire = flags_reg.preacquire;
    assign flag_report     = flags_reg.report;
    assign request_needed  = |flags_reg;
    assign request_count   = count_reg;
    assign reported_usage  = usage_reg;
    assign adjust_needed   = adj_reg;

    // The input stage only holds back when the result stage is full and stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result stage can advance");

    a_acq_rel_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(flag_acquire && flag_release))
        else $error("acquire and release flagged together");

    a_usage_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !flag_report) |-> (reported_usage == '0))
        else $error("usage reported without report flag");

    a_count_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !flag_acquire && !flag_release && !flag_preacquire)
            |-> (request_count == '0))
        else $error("count set without a space request");

endmodule

`default_nettype wire

### dv/tb_quota_grant_request_calc.sv
`timescale 1ns / 1ps

module tb_quota_grant_request_calc;
    import qgrc_pkg::*;

    localparam int SW = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [SW-1:0] ONES = '1;

    // Snapshot of a quota entry as it crosses the input channel.
    typedef struct packed {
        logic [1:0]    mode;
        logic          enforced;
        logic [SW-1:0] disk_usage;
        logic [SW-1:0] pending_writes;
        logic [SW-1:0] waiting_writes;
        logic [SW-1:0] granted_space;
        logic [SW-1:0] pending_release;
        logic [SW-1:0] quota_unit;
        logic [SW-1:0] tune_margin;
        logic          over_quota;
        logic          no_preacquire;
        logic          id_lock_held;
    } snap_t;

    typedef struct packed {
        logic          request_needed;
        logic          flag_acquire;
        logic          flag_release;
        logic          flag_preacquire;
        logic          flag_report;
        logic [SW-1:0] request_count;
        logic [SW-1:0] reported_usage;
        logic          adjust_needed;
    } grant_t;

    // Four spare bits hold any sum of up to five space values exactly.
    typedef logic [SW+3:0] wide_t;

    logic          clk;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic          cfg_data = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [1:0]    mode = '0;
    logic          enforced = 1'b0;
    logic [SW-1:0] disk_usage = '0;
    logic [SW-1:0] pending_writes = '0;
    logic [SW-1:0] waiting_writes = '0;
    logic [SW-1:0] granted_space = '0;
    logic [SW-1:0] pending_release = '0;
    logic [SW-1:0] quota_unit = '0;
    logic [SW-1:0] tune_margin = '0;
    logic          over_quota = 1'b0;
    logic          no_preacquire = 1'b0;
    logic          id_lock_held = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          request_needed;
    logic          flag_acquire;
    logic          flag_release;
    logic          flag_preacquire;
    logic          flag_report;
    logic [SW-1:0] request_count;
    logic [SW-1:0] reported_usage;
    logic          adjust_needed;

    logic   stopping_model = 1'b0;
    grant_t grant_q[$];
    grant_t oldest_grant;
    snap_t  seen_snap;
    int     mismatch_count = 0;
    int     results_checked = 0;
    int     items_sent = 0;
    int     cycle_count = 0;
    int     stall_left = 0;
    int     stall_style = 0;

    quota_grant_request_calc #(
        .SPACE_WIDTH(SW)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .enforced       (enforced),
        .disk_usage     (disk_usage),
        .pending_writes (pending_writes),
        .waiting_writes (waiting_writes),
        .granted_space  (granted_space),
        .pending_release(pending_release),
        .quota_unit     (quota_unit),
        .tune_margin    (tune_margin),
        .over_quota     (over_quota),
        .no_preacquire  (no_preacquire),
        .id_lock_held   (id_lock_held),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .request_needed (request_needed),
        .flag_acquire   (flag_acquire),
        .flag_release   (flag_release),
        .flag_preacquire(flag_preacquire),
        .flag_report    (flag_report),
        .request_count  (request_count),
        .reported_usage (reported_usage),
        .adjust_needed  (adjust_needed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic wide_t widen(input logic [SW-1:0] x);
        return {4'b0000, x};
    endfunction

    function automatic logic [SW-1:0] sat_space(input wide_t x);
        return (x[SW+3:SW] != 0) ? ONES : x[SW-1:0];
    endfunction

    function automatic grant_t calc_grant(input snap_t s, input logic stopping);
        wide_t  du;
        wide_t  gr;
        wide_t  qu;
        wide_t  qt;
        wide_t  pr;
        wide_t  tot;
        wide_t  c;
        wide_t  g;
        mode_t  op;
        logic   done;
        grant_t r;
        r = '0;
        du = widen(s.disk_usage);
        gr = widen(s.granted_space);
        qu = widen(s.quota_unit);
        qt = widen(s.tune_margin);
        pr = widen(s.pending_release);
        tot = du + widen(s.pending_writes) + widen(s.waiting_writes);
        op = mode_t'(s.mode);
        done = 1'b0;
        if (s.enforced || op == MODE_RELEASE)
        begin
            if (op == MODE_ADJUST)
            begin
                // Without the lock and with spare grant, adjust behaves as report.
                if (!s.id_lock_held && gr > du)
                    op = MODE_REPORT;
                else
                begin
                    done = 1'b1;
                    if (tot + qu < gr)
                    begin
                        c = gr - tot;
                        if (tot != 0)
                        begin
                            c = c - qu;
                            if (c < qt)
                                c = qt;
                        end
                        r.request_count = sat_space(c);
                        r.flag_release = 1'b1;
                    end
                    else
                    begin
                        g = gr;
                        if (du > gr)
                        begin
                            r.flag_report = 1'b1;
                            r.reported_usage = s.disk_usage;
                            g = du;
                        end
                        if (!s.over_quota && !s.no_preacquire && s.id_lock_held &&
                            qu != 0 && g < tot + qt)
                        begin
                            r.request_count = (tot < g) ? sat_space(g - tot) : '0;
                            r.flag_preacquire = 1'b1;
                        end
                    end
                end
            end
            if (!done && op == MODE_REPORT)
            begin
                if (du == 0 && gr != 0)
                    op = MODE_RELEASE;
                else if (du < gr)
                    r.flag_acquire = 1'b1;
                else if (du > gr)
                begin
                    r.flag_report = 1'b1;
                    r.reported_usage = s.disk_usage;
                end
            end
            if (!done && op == MODE_RELEASE && gr > du)
            begin
                r.request_count = s.granted_space - s.disk_usage;
                r.flag_release = 1'b1;
            end
            if (!done && op == MODE_ACQUIRE)
            begin
                g = gr;
                if (du > gr)
                begin
                    r.flag_report = 1'b1;
                    r.reported_usage = s.disk_usage;
                    g = du;
                end
                if (g < tot)
                begin
                    r.request_count = sat_space(tot - g);
                    r.flag_acquire = 1'b1;
                end
            end
        end
        if (s.enforced && !stopping)
        begin
            if (!s.id_lock_held && gr > du)
                r.adjust_needed = 1'b1;
            else if (tot + qu + pr < gr)
                r.adjust_needed = 1'b1;
            else if (du > gr)
                r.adjust_needed = 1'b1;
            else if (!s.over_quota && !s.no_preacquire && qu != 0 && gr < tot + qt + pr)
                r.adjust_needed = 1'b1;
        end
        r.request_needed = r.flag_acquire | r.flag_release | r.flag_preacquire |
                           r.flag_report;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [SW-1:0] exp_v,
                               input logic [SW-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Results are compared before the item of the same edge is queued; an item
    // can never leave on the edge that accepts it.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                mismatch_count++;
            end
            else
            begin
                oldest_grant = grant_q.pop_front();
                check_field("request_needed", oldest_grant.request_needed, request_needed);
                check_field("flag_acquire", oldest_grant.flag_acquire, flag_acquire);
                check_field("flag_release", oldest_grant.flag_release, flag_release);
                check_field("flag_preacquire", oldest_grant.flag_preacquire, flag_preacquire);
                check_field("flag_report", oldest_grant.flag_report, flag_report);
                check_field("request_count", oldest_grant.request_count, request_count);
                check_field("reported_usage", oldest_grant.reported_usage, reported_usage);
                check_field("adjust_needed", oldest_grant.adjust_needed, adjust_needed);
                results_checked++;
            end
        end
        if (in_valid && !in_stall)
        begin
            seen_snap = '{mode, enforced, disk_usage, pending_writes, waiting_writes,
                          granted_space, pending_release, quota_unit, tune_margin,
                          over_quota, no_preacquire, id_lock_held};
            grant_q.push_back(calc_grant(seen_snap, stopping_model));
        end
    end

    // The receiver switches between free flow, light, heavy and periodic stalls.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_left <= $urandom_range(5, 40);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_snapshot(input snap_t s);
        in_valid <= 1'b1;
        mode <= s.mode;
        enforced <= s.enforced;
        disk_usage <= s.disk_usage;
        pending_writes <= s.pending_writes;
        waiting_writes <= s.waiting_writes;
        granted_space <= s.granted_space;
        pending_release <= s.pending_release;
        quota_unit <= s.quota_unit;
        tune_margin <= s.tune_margin;
        over_quota <= s.over_quota;
        no_preacquire <= s.no_preacquire;
        id_lock_held <= s.id_lock_held;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_stopping(input logic value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        stopping_model = value;
        @(posedge clk);
    endtask

    function automatic snap_t make_snap(input mode_t m, input logic enf,
                                        input logic [SW-1:0] du, pw, ww, gr, pr, qu, qt,
                                        input logic edq, nopre, lock);
        return '{m, enf, du, pw, ww, gr, pr, qu, qt, edq, nopre, lock};
    endfunction

    function automatic logic [SW-1:0] rand_space();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONES;
            2, 3, 4: return SW'($urandom_range(0, 1000));
            5, 6: return SW'($urandom);
            7, 8: return {$urandom, $urandom};
            default: return ~SW'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic snap_t rand_snapshot();
        snap_t s;
        s.mode = 2'($urandom_range(0, 3));
        s.enforced = ($urandom_range(0, 7) != 0);
        s.disk_usage = rand_space();
        s.pending_writes = rand_space();
        s.waiting_writes = rand_space();
        s.granted_space = rand_space();
        s.pending_release = ($urandom_range(0, 1) == 0) ? '0 : rand_space();
        s.quota_unit = rand_space();
        s.tune_margin = rand_space();
        s.over_quota = ($urandom_range(0, 3) == 0);
        s.no_preacquire = ($urandom_range(0, 3) == 0);
        s.id_lock_held = 1'($urandom_range(0, 1));
        // Half of the snapshots keep the grant close to real usage, where the
        // release, pre-acquire and report decisions are made.
        case ($urandom_range(0, 3))
            0:
            begin
                s.pending_writes = SW'($urandom_range(0, 500));
                s.waiting_writes = SW'($urandom_range(0, 500));
                s.granted_space = s.disk_usage + SW'($urandom_range(0, 3000)) -
                                  SW'($urandom_range(0, 1500));
            end
            1:
            begin
                s.disk_usage = SW'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 300));
                s.pending_writes = SW'($urandom_range(0, 200));
                s.waiting_writes = '0;
                s.quota_unit = SW'($urandom_range(0, 400));
                s.tune_margin = SW'($urandom_range(0, 800));
                s.pending_release = SW'($urandom_range(0, 600));
                s.granted_space = s.disk_usage + SW'($urandom_range(0, 2000));
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic run_random_bursts(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < n_items; k++)
            begin
                send_snapshot(rand_snapshot());
                sent++;
            end
            idle_cycles($urandom_range(1, 5));
        end
    endtask

    task automatic test_directed();
        // acquire: plain, with usage above grant, saturating count, and not enforced
        send_snapshot(make_snap(MODE_ACQUIRE, 1, 100, 50, 25, 120, 0, 0, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_ACQUIRE, 1, 200, 10, 0, 100, 0, 0, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_ACQUIRE, 1, ONES, ONES, ONES, 0, 0, 0, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_ACQUIRE, 0, 100, 50, 25, 0, 0, 0, 0, 0, 0, 1));
        // report: falls through to release, grant above, below and equal to usage
        send_snapshot(make_snap(MODE_REPORT, 1, 0, 0, 0, 500, 0, 0, 0, 0, 0, 0));
        send_snapshot(make_snap(MODE_REPORT, 1, 10, 0, 0, 500, 0, 0, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_REPORT, 1, 600, 0, 0, 500, 0, 0, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_REPORT, 1, 500, 0, 0, 500, 0, 0, 0, 0, 0, 1));
        // release works even when not enforced
        send_snapshot(make_snap(MODE_RELEASE, 0, 300, 0, 0, 1000, 0, 0, 0, 0, 0, 0));
        send_snapshot(make_snap(MODE_RELEASE, 1, 1000, 0, 0, 300, 0, 0, 0, 0, 0, 1));
        // adjust without the lock acts as report, and then as release
        send_snapshot(make_snap(MODE_ADJUST, 1, 100, 0, 0, 900, 0, 0, 0, 0, 0, 0));
        send_snapshot(make_snap(MODE_ADJUST, 1, 0, 0, 0, 900, 0, 0, 0, 0, 0, 0));
        // adjust release: nothing in use, normal, and raised to the tune margin
        send_snapshot(make_snap(MODE_ADJUST, 1, 0, 0, 0, 1000, 0, 10, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 100, 0, 0, 1000, 0, 100, 50, 0, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 100, 0, 0, 300, 0, 150, 500, 0, 0, 1));
        // adjust pre-acquire, with and without reported usage, then blocked
        send_snapshot(make_snap(MODE_ADJUST, 1, 50, 0, 0, 100, 0, 100, 200, 0, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 500, 0, 0, 100, 0, 1, 1000, 0, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 50, 0, 0, 100, 0, 0, 200, 0, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 50, 0, 0, 100, 0, 100, 200, 1, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 50, 0, 0, 100, 0, 100, 200, 0, 1, 1));
        // pending release only changes the adjustment decision
        send_snapshot(make_snap(MODE_ADJUST, 1, 100, 0, 0, 100, ONES, 0, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 100, 0, 0, 100, ONES, 5, 0, 0, 0, 1));
        send_snapshot(make_snap(MODE_ADJUST, 1, 100, 0, 0, 1000, 950, 10, 0, 0, 0, 1));
        // all ones, and adjust when not enforced
        send_snapshot(make_snap(MODE_ADJUST, 1, ONES, ONES, ONES, ONES, ONES, ONES, ONES,
                                1, 1, 1));
        send_snapshot(make_snap(MODE_ADJUST, 0, 0, 0, 0, 500, 0, 10, 10, 0, 0, 1));
        drain_results();
    endtask

    task automatic test_stopping();
        write_stopping(1'b1);
        send_snapshot(make_snap(MODE_ADJUST, 1, 100, 0, 0, 900, 0, 0, 0, 0, 0, 0));
        run_random_bursts(150);
        drain_results();
        write_stopping(1'b0);
    endtask

    task automatic test_random(input int n_items);
        run_random_bursts(n_items / 2);
        // Hold the sender off until the pipeline has emptied.
        drain_results();
        run_random_bursts(n_items - n_items / 2);
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_stopping(1'b0);
        test_directed();
        test_stopping();
        test_random(650);
        repeat (10) @(posedge clk);
        $display("Sent %0d items over all four modes with target_stopping at 0 and 1.",
                 items_sent);
        $display("Compared %0d results, %0d field mismatches.", results_checked,
                 mismatch_count);
        if (mismatch_count == 0 && grant_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
